// ----- rtl/core/tss_pkg.sv -----
// Shared types and constants for the trigger step sequencer track.
package tss_pkg;
    localparam int unsigned PULSE_TICKS = 240;
    localparam int unsigned PERIOD_MIN  = 100;
    localparam int unsigned PERIOD_MAX  = 96000;
    localparam int unsigned TICKS_SAT   = 131071;
    localparam int unsigned PERIOD_RST  = 4800;

    // ceil(2^26 / 25): (x >> 3) * SWING_RECIP >> 26 gives x / 200 for x below 2^24
    localparam logic [21:0] SWING_RECIP = 22'd2684355;

    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_DIR    = 3'd1;
    localparam logic [2:0] REG_RATE   = 3'd2;
    localparam logic [2:0] REG_SWING  = 3'd3;
    localparam logic [2:0] REG_SPLIT  = 3'd4;
    localparam logic [2:0] REG_REP1   = 3'd5;
    localparam logic [2:0] REG_REP2   = 3'd6;
    localparam logic [2:0] REG_FILL   = 3'd7;

    localparam logic [1:0] DIR_FWD    = 2'd0;
    localparam logic [1:0] DIR_BWD    = 2'd1;
    localparam logic [1:0] DIR_BOUNCE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_DIV,
        ST_SUB,
        ST_HIT,
        ST_SWMUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic edge_step;
        logic start_div;
        logic sub_check;
        logic hit_check;
        logic start_swing;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic div_done;
        logic need_swing;
    } t_status;
endpackage

// ----- rtl/core/tss_divider.sv -----
// Radix-2 restoring divider, 17-bit dividend by 17-bit divisor.
module tss_divider import tss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_quotient
);
    logic [16:0] r_q, n_q;
    logic [17:0] r_rem, n_rem;
    logic [16:0] r_d;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_shift;

    always_comb begin
        w_shift = {r_rem[16:0], r_q[16]};
        n_q = {r_q[15:0], 1'b0};
        n_rem = w_shift;
        if (w_shift >= {1'b0, r_d}) begin
            n_rem = w_shift - {1'b0, r_d};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd16) r_busy <= 1'b0;
        end
    end

    assign o_done     = r_busy && (r_cnt == 5'd16);
    assign o_quotient = n_q;
endmodule

// ----- rtl/core/tss_ctrl.sv -----
// Controller state machine for one tick or write item.
module tss_ctrl import tss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid && !r_out_valid) n_state = ST_EDGE;
            ST_EDGE:  n_state = i_status.is_write ? ST_FIN : ST_DIV;
            ST_DIV:   if (i_status.div_done) n_state = ST_SUB;
            ST_SUB:   n_state = ST_HIT;
            ST_HIT:   n_state = i_status.need_swing ? ST_SWMUL : ST_FIN;
            ST_SWMUL: n_state = ST_FIN;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:  o_cmd.load = i_in_valid && !r_out_valid;
            ST_EDGE:  begin
                o_cmd.edge_step = !i_status.is_write;
                o_cmd.start_div = !i_status.is_write;
            end
            ST_DIV:   ;
            ST_SUB:   o_cmd.sub_check = 1'b1;
            ST_HIT:   o_cmd.hit_check = 1'b1;
            ST_SWMUL: o_cmd.start_swing = 1'b1;
            ST_FIN:   o_cmd.finish = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/core/tss_datapath.sv -----
// Datapath: pattern store, counters, step logic and swing/gate timing.
module tss_datapath import tss_pkg::*; #(
    parameter int FRAMES_PER_TICK = 1,
    parameter int PATTERN_STEPS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_opcode,
    input  logic        i_clock_high,
    input  logic        i_reset_high,
    input  logic [4:0]  i_step_index,
    input  logic        i_step_on,
    output logic        o_gate,
    output logic [4:0]  o_position
);
    localparam int IW = $clog2(PATTERN_STEPS);

    logic [5:0] r_len_cfg, r_fill;
    logic [1:0] r_dir;
    logic [4:0] r_rate, r_split;
    logic [6:0] r_swing, r_rep1, r_rep2;

    logic [PATTERN_STEPS-1:0] r_pat;
    logic [6:0]  r_pos;
    logic        r_fwd, r_sec2;
    logic [6:0]  r_cnt1, r_cnt2;
    logic [3:0]  r_divc;
    logic [4:0]  r_subc;
    logic [16:0] r_period, r_ticks;
    logic [16:0] r_swait;
    logic [7:0]  r_pulse;
    logic        r_pclk, r_prst;
    logic        r_op, r_clk, r_rst, r_on;
    logic [4:0]  r_idx;
    logic        r_stepped, r_cedge;
    logic [23:0] r_swprod;
    logic [16:0] r_quo_q;

    logic        w_div_start, w_div_done;
    logic [16:0] w_dvd, w_dvs, w_quo;

    tss_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_div_done), .o_quotient(w_quo)
    );

    logic        w_dividing;
    logic [4:0]  w_divisor, w_mult;
    assign w_dividing = r_rate < 5'd15;
    assign w_divisor  = 5'd16 - r_rate;
    assign w_mult     = w_dividing ? 5'd1 : r_rate - 5'd14;

    // advance() on a copy of step state
    typedef struct packed {
        logic [6:0] pos;
        logic       fwd;
        logic       sec2;
        logic [6:0] c1;
        logic [6:0] c2;
    } t_pstate;

    function automatic t_pstate f_advance(t_pstate s, logic [5:0] lcfg, logic [1:0] dir,
                                          logic [4:0] split, logic [6:0] r1, logic [6:0] r2,
                                          logic [5:0] fill);
        t_pstate o;
        logic signed [7:0] len, sp, e1, p, fl;
        o = s;
        len = (lcfg == 6'd0) ? 8'sd1 : {2'b0, lcfg};
        if (len > 8'(PATTERN_STEPS)) len = 8'(PATTERN_STEPS);
        sp = {3'b0, split};
        fl = {2'b0, fill};
        p  = {1'b0, s.pos};
        e1 = (sp > 0) ? sp : len;
        if (dir == DIR_BOUNCE || (sp >= len && dir == DIR_BOUNCE)) begin
            if (s.fwd) begin
                p = p + 8'sd1;
                if (p >= len) begin
                    p = len - 8'sd2;
                    if (p < 0) p = 8'sd0;
                    o.fwd = 1'b0;
                end
            end else begin
                p = p - 8'sd1;
                if (p < 0) begin
                    p = 8'sd1;
                    if (p >= len) p = len - 8'sd1;
                    o.fwd = 1'b1;
                end
            end
        end else if (sp >= len) begin
            if (dir == DIR_FWD) begin
                p = p + 8'sd1;
                if (p >= len) p = 8'sd0;
            end else if (dir == DIR_BWD) begin
                p = p - 8'sd1;
                if (p < 0) p = len - 8'sd1;
            end
        end else if (dir == DIR_FWD) begin
            p = p + 8'sd1;
            if (!s.sec2 && sp > 0 && fl > 0 && fl < sp && r1 > 7'd1 &&
                s.c1 == r1 - 7'd1 && p >= fl) begin
                o.c1 = '0; o.sec2 = 1'b1; p = sp;
            end else if (!s.sec2 && p >= e1) begin
                if (s.c1 + 7'd1 >= r1) begin
                    o.c1 = '0; o.sec2 = 1'b1; p = sp;
                end else begin
                    o.c1 = s.c1 + 7'd1; p = 8'sd0;
                end
            end else if (s.sec2 && p >= len) begin
                if (s.c2 + 7'd1 >= r2) begin
                    o.c2 = '0; o.sec2 = 1'b0; p = 8'sd0;
                end else begin
                    o.c2 = s.c2 + 7'd1; p = sp;
                end
            end
        end else if (dir == DIR_BWD) begin
            p = p - 8'sd1;
            if (s.sec2 && p < sp) begin
                if (s.c2 + 7'd1 >= r2) begin
                    o.c2 = '0; o.sec2 = 1'b0; p = e1 - 8'sd1;
                end else begin
                    o.c2 = s.c2 + 7'd1; p = len - 8'sd1;
                end
            end else if (!s.sec2 && p < 0) begin
                if (s.c1 + 7'd1 >= r1) begin
                    o.c1 = '0; o.sec2 = 1'b1; p = len - 8'sd1;
                end else begin
                    o.c1 = s.c1 + 7'd1; p = e1 - 8'sd1;
                end
            end
        end
        o.pos = p[6:0];
        return o;
    endfunction

    t_pstate w_cur, w_adv;
    assign w_cur = '{pos: r_pos, fwd: r_fwd, sec2: r_sec2, c1: r_cnt1, c2: r_cnt2};
    assign w_adv = f_advance(w_cur, r_len_cfg, r_dir, r_split, r_rep1, r_rep2, r_fill);

    assign w_div_start = i_cmd.start_div;
    assign w_dvd = r_period;
    assign w_dvs = {12'd0, w_mult};

    logic [17:0] w_tick_sum;
    logic        w_redge, w_cedge, w_div_wrap;
    logic [3:0]  w_divc;
    logic        w_sub_hit, w_hit, w_odd;
    logic [22:0] w_subtgt;
    logic [23:0] w_prod;
    logic [20:0] w_sw8;
    logic [42:0] w_swrec;
    logic [16:0] w_swq;

    assign w_redge    = r_rst && !r_prst;
    assign w_cedge    = r_clk && !r_pclk;
    assign w_divc     = w_redge ? 4'd0 : r_divc;
    assign w_div_wrap = ({1'b0, w_divc} + 5'd1) >= w_divisor;

    always_comb begin
        w_tick_sum = w_redge ? 18'(FRAMES_PER_TICK) : {1'b0, r_ticks} + 18'(FRAMES_PER_TICK);
        if (w_tick_sum > 18'(TICKS_SAT)) w_tick_sum = 18'(TICKS_SAT);
    end

    assign w_subtgt = {6'd0, r_quo_q} * ({1'b0, r_subc} + 6'd1);
    assign w_sub_hit = !w_dividing && w_mult > 5'd1 && !r_cedge && r_period != 17'd0 &&
                       r_quo_q > 17'(FRAMES_PER_TICK) && {6'd0, r_ticks} >= w_subtgt;
    assign w_hit = r_stepped && (r_pos < 7'(PATTERN_STEPS)) && r_pat[r_pos[IW-1:0]];
    assign w_odd = r_pos[0] && r_swing != 7'd0;
    assign w_prod = r_period * r_swing;

    // swing delay = period * swing / 200
    assign w_sw8   = r_swprod[23:3];
    assign w_swrec = {22'd0, w_sw8} * {21'd0, SWING_RECIP};
    assign w_swq   = w_swrec[42:26];

    assign o_status.is_write   = r_op;
    assign o_status.div_done   = w_div_done;
    assign o_status.need_swing = w_hit && w_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= 6'd16; r_dir <= DIR_FWD; r_rate <= 5'd14; r_swing <= '0;
            r_split <= '0; r_rep1 <= 7'd1; r_rep2 <= 7'd1; r_fill <= 6'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LENGTH: r_len_cfg <= i_cfg_data[5:0];
                REG_DIR:    r_dir     <= i_cfg_data[1:0];
                REG_RATE:   r_rate    <= i_cfg_data[4:0];
                REG_SWING:  r_swing   <= i_cfg_data;
                REG_SPLIT:  r_split   <= i_cfg_data[4:0];
                REG_REP1:   r_rep1    <= i_cfg_data;
                REG_REP2:   r_rep2    <= i_cfg_data;
                REG_FILL:   r_fill    <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode; r_clk <= i_clock_high; r_rst <= i_reset_high;
            r_idx <= i_step_index; r_on <= i_step_on;
        end
        if (w_div_done) r_quo_q <= w_quo;
        if (i_cmd.hit_check) r_swprod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0; r_pos <= '0; r_fwd <= 1'b1; r_sec2 <= 1'b0;
            r_cnt1 <= '0; r_cnt2 <= '0; r_divc <= '0; r_subc <= '0;
            r_period <= 17'(PERIOD_RST); r_ticks <= '0; r_swait <= '0; r_pulse <= '0;
            r_pclk <= 1'b0; r_prst <= 1'b0; r_stepped <= 1'b0; r_cedge <= 1'b0;
        end else begin
            if (i_cmd.edge_step) begin
                r_pclk <= r_clk; r_prst <= r_rst;
                r_cedge <= w_cedge;
                r_stepped <= w_cedge && (!w_dividing || w_div_wrap);
                if (w_redge) begin
                    r_pos <= '0; r_fwd <= 1'b1; r_sec2 <= 1'b0; r_cnt1 <= '0;
                    r_cnt2 <= '0; r_swait <= '0;
                end
                if (w_redge || w_cedge) r_subc <= '0;
                if (w_cedge) begin
                    if (w_tick_sum > 18'(PERIOD_MIN) && w_tick_sum < 18'(PERIOD_MAX))
                        r_period <= w_tick_sum[16:0];
                    r_ticks <= '0;
                end else begin
                    r_ticks <= w_tick_sum[16:0];
                end
                if (w_cedge && w_dividing) begin
                    if (w_div_wrap) r_divc <= '0;
                    else r_divc <= w_divc + 4'd1;
                end else if (w_redge) begin
                    r_divc <= '0;
                end
            end
            if (i_cmd.sub_check) begin
                if (r_stepped) begin
                    r_pos <= w_adv.pos; r_fwd <= w_adv.fwd; r_sec2 <= w_adv.sec2;
                    r_cnt1 <= w_adv.c1; r_cnt2 <= w_adv.c2;
                end else if (w_sub_hit) begin
                    if (r_subc != 5'd31) r_subc <= r_subc + 5'd1;
                    if ({1'b0, r_subc} + 6'd1 < {1'b0, w_mult}) begin
                        r_pos <= w_adv.pos; r_fwd <= w_adv.fwd; r_sec2 <= w_adv.sec2;
                        r_cnt1 <= w_adv.c1; r_cnt2 <= w_adv.c2;
                        r_stepped <= 1'b1;
                    end
                end
            end
            if (i_cmd.hit_check && w_hit && !w_odd) r_pulse <= 8'(PULSE_TICKS);
            if (i_cmd.start_swing) begin
                if (w_swq == 17'd0) r_pulse <= 8'(PULSE_TICKS);
                else r_swait <= w_swq;
            end
            if (i_cmd.finish) begin
                if (r_op) begin
                    if (7'(r_idx) < 7'(PATTERN_STEPS)) r_pat[IW'(r_idx)] <= r_on;
                end else begin
                    logic [7:0] w_p;
                    w_p = r_pulse;
                    if (r_swait != 17'd0) begin
                        if (r_swait <= 17'(FRAMES_PER_TICK)) begin
                            r_swait <= '0;
                            w_p = 8'(PULSE_TICKS);
                        end else begin
                            r_swait <= r_swait - 17'(FRAMES_PER_TICK);
                        end
                    end
                    if (w_p != 8'd0) begin
                        if (w_p <= 8'(FRAMES_PER_TICK)) r_pulse <= '0;
                        else r_pulse <= w_p - 8'(FRAMES_PER_TICK);
                    end else begin
                        r_pulse <= '0;
                    end
                end
            end
        end
    end

    assign o_gate     = r_pulse != 8'd0;
    assign o_position = r_pos[4:0];
endmodule

// ----- rtl/core/trigger_step_sequencer_track.sv -----
// Top level of one trigger step sequencer track.
//  channel | valid       | ready       | payload
//  in      | i_in_valid  | o_in_ready  | i_opcode i_clock_high i_reset_high i_step_index i_step_on
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index i_cfg_data
//  out     | o_out_valid | i_out_ready | o_gate o_position
// A tick item runs through the 17-step restoring divider (period by multiplier); a write
// item skips it. A new item is taken once the prior result has been taken, so output stalls
// hold off the next item. Synchronous active-low reset clears the control state, the
// configuration, the step state and the pattern; the latched input item, the divider's
// working registers and the latched quotient and swing product are not reset.
module trigger_step_sequencer_track import tss_pkg::*; #(
    parameter int FRAMES_PER_TICK = 1,
    parameter int PATTERN_STEPS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic       i_clock_high,
    input  logic       i_reset_high,
    input  logic [4:0] i_step_index,
    input  logic       i_step_on,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_gate,
    output logic [4:0] o_position
);
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    tss_datapath #(.FRAMES_PER_TICK(FRAMES_PER_TICK), .PATTERN_STEPS(PATTERN_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_clock_high(i_clock_high), .i_reset_high(i_reset_high),
        .i_step_index(i_step_index), .i_step_on(i_step_on),
        .o_gate(o_gate), .o_position(o_position)
    );
endmodule

// ----- tb/trigger_step_sequencer_track_check.sv -----
// Checker for the trigger step sequencer track: tracks state, predicts each result, compares.
`timescale 1ns / 1ps
module trigger_step_sequencer_track_check import tss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_opcode,
    input  logic       i_clock_high,
    input  logic       i_reset_high,
    input  logic [4:0] i_step_index,
    input  logic       i_step_on,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_gate,
    input  logic [4:0] i_position,
    output int         o_errors,
    output int         o_pending
);
    typedef struct packed {
        logic       gate;
        logic [4:0] position;
    } t_track_out;

    t_track_out expected_q[$];

    logic        pattern [32];
    int          pos;
    logic        fwd_bounce;
    int          rep1_cnt, rep2_cnt;
    logic        in_sec2;
    int unsigned div_cnt, sub_cnt, period, tick_cnt;
    int          swing_left, pulse_left;
    logic        prev_clk, prev_rst;

    logic [5:0]  len_reg;
    logic [1:0]  dir_reg;
    logic [4:0]  rate_reg;
    logic [6:0]  swing_reg;
    logic [4:0]  split_reg;
    logic [6:0]  rep1_reg, rep2_reg;
    logic [5:0]  fill_reg;

    assign o_pending = expected_q.size();

    task automatic bounce(input int len);
        if (fwd_bounce) begin
            pos++;
            if (pos >= len) begin
                pos = len - 2;
                if (pos < 0) pos = 0;
                fwd_bounce = 1'b0;
            end
        end else begin
            pos--;
            if (pos < 0) begin
                pos = 1;
                if (pos >= len) pos = len - 1;
                fwd_bounce = 1'b1;
            end
        end
    endtask

    task automatic move_step();
        int len, split, r1, r2, fill, end1;
        len = len_reg; split = split_reg; r1 = rep1_reg; r2 = rep2_reg; fill = fill_reg;
        if (len < 1) len = 1;
        if (len > 32) len = 32;
        if (split >= len) begin
            if (dir_reg == DIR_FWD) begin
                pos++;
                if (pos >= len) pos = 0;
            end else if (dir_reg == DIR_BWD) begin
                pos--;
                if (pos < 0) pos = len - 1;
            end else if (dir_reg == DIR_BOUNCE) begin
                bounce(len);
            end
            return;
        end
        end1 = (split > 0) ? split : len;
        if (dir_reg == DIR_FWD) begin
            pos++;
            if (!in_sec2 && split > 0 && fill > 0 && fill < split && r1 > 1 &&
                rep1_cnt == r1 - 1 && pos >= fill) begin
                rep1_cnt = 0; in_sec2 = 1'b1; pos = split;
            end else if (!in_sec2 && pos >= end1) begin
                rep1_cnt++;
                if (rep1_cnt >= r1) begin
                    rep1_cnt = 0; in_sec2 = 1'b1; pos = split;
                end else pos = 0;
            end else if (in_sec2 && pos >= len) begin
                rep2_cnt++;
                if (rep2_cnt >= r2) begin
                    rep2_cnt = 0; in_sec2 = 1'b0; pos = 0;
                end else pos = split;
            end
        end else if (dir_reg == DIR_BWD) begin
            pos--;
            if (in_sec2 && pos < split) begin
                rep2_cnt++;
                if (rep2_cnt >= r2) begin
                    rep2_cnt = 0; in_sec2 = 1'b0; pos = end1 - 1;
                end else pos = len - 1;
            end else if (!in_sec2 && pos < 0) begin
                rep1_cnt++;
                if (rep1_cnt >= r1) begin
                    rep1_cnt = 0; in_sec2 = 1'b1; pos = len - 1;
                end else pos = end1 - 1;
            end
        end else if (dir_reg == DIR_BOUNCE) begin
            bounce(len);
        end
    endtask

    task automatic sample_tick(input logic clk_lvl, input logic rst_lvl);
        logic        clk_edge, rst_edge, dividing, stepped;
        int unsigned divisor, mult, sub, delay;
        clk_edge = clk_lvl && !prev_clk;
        rst_edge = rst_lvl && !prev_rst;
        dividing = rate_reg < 15;
        divisor = dividing ? 16 - rate_reg : 1;
        mult = dividing ? 1 : rate_reg - 14;
        stepped = 1'b0;
        prev_clk = clk_lvl;
        prev_rst = rst_lvl;
        if (rst_edge) begin
            pos = 0; fwd_bounce = 1'b1; swing_left = 0; rep1_cnt = 0; rep2_cnt = 0;
            in_sec2 = 1'b0; div_cnt = 0; sub_cnt = 0; tick_cnt = 0;
        end
        tick_cnt += 1;
        if (tick_cnt > TICKS_SAT) tick_cnt = TICKS_SAT;
        if (clk_edge) begin
            if (tick_cnt > PERIOD_MIN && tick_cnt < PERIOD_MAX) period = tick_cnt;
            tick_cnt = 0;
            sub_cnt = 0;
            if (dividing) begin
                div_cnt++;
                if (div_cnt >= divisor) begin
                    div_cnt = 0; move_step(); stepped = 1'b1;
                end
            end else begin
                move_step(); stepped = 1'b1;
            end
        end
        if (!dividing && mult > 1 && !clk_edge && period > 0) begin
            sub = period / mult;
            if (sub > 1 && tick_cnt >= sub * (sub_cnt + 1)) begin
                if (sub_cnt < 31) sub_cnt++;
                if (sub_cnt < mult) begin
                    move_step(); stepped = 1'b1;
                end
            end
        end
        if (stepped && pos >= 0 && pos < 32 && pattern[pos]) begin
            delay = 0;
            if (pos[0] && swing_reg > 0) delay = (period * swing_reg) / 200;
            if (delay == 0) pulse_left = PULSE_TICKS;
            else swing_left = delay;
        end
        if (swing_left > 0) begin
            swing_left -= 1;
            if (swing_left <= 0) begin
                swing_left = 0; pulse_left = PULSE_TICKS;
            end
        end
        if (pulse_left > 0) pulse_left -= 1;
    endtask

    always @(posedge i_clk) begin
        t_track_out got, want;
        if (!i_rst_n) begin
            foreach (pattern[k]) pattern[k] = 1'b0;
            pos = 0; fwd_bounce = 1'b1; rep1_cnt = 0; rep2_cnt = 0; in_sec2 = 1'b0;
            div_cnt = 0; sub_cnt = 0; period = PERIOD_RST; tick_cnt = 0;
            swing_left = 0; pulse_left = 0; prev_clk = 1'b0; prev_rst = 1'b0;
            len_reg = 16; dir_reg = DIR_FWD; rate_reg = 14; swing_reg = 0; split_reg = 0;
            rep1_reg = 1; rep2_reg = 1; fill_reg = 1;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LENGTH: len_reg = i_cfg_data[5:0];
                    REG_DIR:    dir_reg = i_cfg_data[1:0];
                    REG_RATE:   rate_reg = i_cfg_data[4:0];
                    REG_SWING:  swing_reg = i_cfg_data;
                    REG_SPLIT:  split_reg = i_cfg_data[4:0];
                    REG_REP1:   rep1_reg = i_cfg_data;
                    REG_REP2:   rep2_reg = i_cfg_data;
                    REG_FILL:   fill_reg = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.gate = i_gate;
                got.position = i_position;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result gate=%0d position=%0d",
                             $time, got.gate, got.position);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        $display("%0t: expected gate=%0d position=%0d, got gate=%0d position=%0d",
                                 $time, want.gate, want.position, got.gate, got.position);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode) pattern[i_step_index] = i_step_on;
                else sample_tick(i_clock_high, i_reset_high);
                want.gate = pulse_left > 0;
                want.position = pos[4:0];
                expected_q.push_back(want);
            end
        end
    end
endmodule

// ----- tb/trigger_step_sequencer_track_test.sv -----
// Testbench top for the trigger step sequencer track: stimulus, idling and verdict.
`timescale 1ns / 1ps
module trigger_step_sequencer_track_test import tss_pkg::*;;
    logic       i_clk, i_rst_n;
    logic       in_valid, in_ready, opcode, clock_high, reset_high, step_on;
    logic [4:0] step_index;
    logic       cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [6:0] cfg_data;
    logic       out_valid, out_ready, gate;
    logic [4:0] position;
    int         errors, pending, idle_cycles;
    logic       calm;

    trigger_step_sequencer_track dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_opcode(opcode),
        .i_clock_high(clock_high), .i_reset_high(reset_high),
        .i_step_index(step_index), .i_step_on(step_on),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_gate(gate), .o_position(position)
    );

    trigger_step_sequencer_track_check checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_opcode(opcode),
        .i_clock_high(clock_high), .i_reset_high(reset_high),
        .i_step_index(step_index), .i_step_on(step_on),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_gate(gate), .i_position(position),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls in random bursts
    initial begin
        int n;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("trigger_step_sequencer_track_test failed");
                $finish;
            end
        end
    end

    task automatic send(input logic op, input logic ck, input logic rs,
                        input logic [4:0] idx, input logic on);
        int n;
        if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 15);
            repeat (n) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode <= op; clock_high <= ck; reset_high <= rs; step_index <= idx; step_on <= on;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic tick(input logic ck, input logic rs);
        send(1'b0, ck, rs, 5'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random clock train: high/low run lengths chosen per phase, with random pattern writes and rare resets mixed in
    task automatic clock_train(input int items, input int half_lo, input int half_hi);
        int k, h;
        logic lvl;
        lvl = 1'b0; h = 0; k = 0;
        while (k < items) begin
            if (h == 0) begin
                lvl = ~lvl;
                h = $urandom_range(half_lo, half_hi);
            end
            h--;
            if ($urandom_range(0, 15) == 0)
                send(1'b1, 1'b0, 1'b0, 5'($urandom), 1'($urandom));
            else
                tick(lvl, $urandom_range(0, 199) == 0);
            k++;
        end
    endtask

    initial begin
        int ph;
        calm = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0; opcode = 1'b0; clock_high = 1'b0; reset_high = 1'b0;
        step_index = '0; step_on = 1'b0;
        cfg_valid = 1'b0; cfg_index = REG_LENGTH; cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pattern extremes, edges, resets
        send(1'b1, 1'b1, 1'b1, 5'd0, 1'b1);
        send(1'b1, 1'b0, 1'b0, 5'd31, 1'b1);
        send(1'b1, 1'b0, 1'b0, 5'd1, 1'b1);
        send(1'b1, 1'b0, 1'b0, 5'd31, 1'b0);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);
        drain();
        write_reg(REG_RATE, 7'd15);
        write_reg(REG_REP1, 7'd99);
        write_reg(REG_REP2, 7'd99);
        for (int i = 0; i < 8; i++) tick(i[0], 1'b0);
        drain();
        write_reg(REG_DIR, 7'd3);
        write_reg(REG_LENGTH, 7'd0);
        for (int i = 0; i < 4; i++) tick(i[0], 1'b0);
        drain();

        for (int i = 0; i < 32; i++) send(1'b1, 1'b0, 1'b0, 5'(i), 1'($urandom));
        for (ph = 0; ph < 14; ph++) begin
            drain();
            if (ph == 13) calm = 1'b1;
            write_reg(REG_LENGTH, ph == 0 ? 7'd32 : ph == 1 ? 7'd1 :
                      ph == 2 ? 7'd63 : 7'($urandom_range(1, 32)));
            write_reg(REG_DIR, ph < 3 ? 7'(ph) : 7'($urandom_range(0, 3)));
            write_reg(REG_RATE, ph == 3 ? 7'd0 : ph == 4 ? 7'd30 : ph == 5 ? 7'd31 :
                      7'($urandom_range(0, 31)));
            write_reg(REG_SWING, ph == 6 ? 7'd100 : ph == 7 ? 7'd127 :
                      7'($urandom_range(0, 100)));
            write_reg(REG_SPLIT, ph == 8 ? 7'd31 : 7'($urandom_range(0, 15)));
            write_reg(REG_REP1, ph == 9 ? 7'd127 : 7'($urandom_range(1, 4)));
            write_reg(REG_REP2, ph == 9 ? 7'd0 : 7'($urandom_range(1, 4)));
            write_reg(REG_FILL, ph == 10 ? 7'd63 : 7'($urandom_range(0, 16)));
            if (ph == 11) clock_train(40, 1, 4);
            else clock_train(150, ph[0] ? 50 : 2, ph[0] ? 70 : 12);
        end
        drain();
        if (errors == 0) begin
            $display("trigger_step_sequencer_track_test passed");
        end else begin
            $display("trigger_step_sequencer_track_test failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/tss_pkg.sv
rtl/core/tss_divider.sv
rtl/core/tss_ctrl.sv
rtl/core/tss_datapath.sv
rtl/core/trigger_step_sequencer_track.sv
tb/trigger_step_sequencer_track_check.sv
tb/trigger_step_sequencer_track_test.sv
